>>> sv/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

    localparam int unsigned HISTORY_DEPTH = 8192;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_MODE   = 1'b0;
    localparam logic        REG_LENGTH = 1'b1;

    localparam logic [7:0]  FLAG_XOR     = 8'hc8;
    localparam logic [31:0] LENGTH_RESET = 32'hffff_ffff;
    localparam logic [3:0]  GROUP_ITEMS  = 4'd8;

    typedef enum logic [2:0] {
        PH_FLAG = 3'b001,
        PH_ITEM = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    function automatic logic [15:0] match_key(input logic [2:0] sel);
        logic [15:0] k;
        case (sel)
            3'd0:    k = 16'hff21;
            3'd1:    k = 16'h834f;
            3'd2:    k = 16'h675f;
            3'd3:    k = 16'h0034;
            3'd4:    k = 16'hf237;
            3'd5:    k = 16'h815f;
            3'd6:    k = 16'h4765;
            default: k = 16'h0233;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> sv/lzss_ram.sv
`default_nettype none

module lzss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = lzss_pkg::HISTORY_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/lzss_stream_decoder.sv
// LZSS stream decoder, 12-bit distance and 4-bit length, eight items per flag byte.
// Input stream: s_axis carries one compressed byte per request in tdata; tuser
// set restarts the stream (history and output count cleared) before that byte
// is decoded as the first flag byte. Output stream: m_axis carries one
// decompressed byte per request; tlast marks the final byte produced by one
// input byte, tuser marks the byte that reaches the configured output length.
// APB registers: 0x0 obfuscated_mode, 0x4 output_length.
// Flow: the next input byte can be taken while a literal is still in flight; a
// match high byte starts a copy of 2 to 17 bytes, paced by the single read port
// of the history RAM, and no input is taken until its last read is issued. A
// literal passes the stage-1 register, then the output register; a match byte
// passes the RAM read, stage 1 and the output register. A restart request waits
// until the previous byte in flight has been written to history.
// Reset: control state clears at once; history is tracked by a fill pointer
// and a wrap flag, so unwritten entries read as zero with no clearing sweep.
// When the receiver stalls, the output register holds, the copy pipeline
// freezes and s_axis_tready stays low until the output is taken.

`default_nettype none

module lzss_stream_decoder #(
    parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // in_byte
    input  wire logic                            s_axis_tuser,  // stream_start

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [7:0]                      m_axis_tdata,  // out_byte
    output logic                                 m_axis_tlast,  // run_last
    output logic                                 m_axis_tuser,  // stream_done

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lzss_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(HISTORY_DEPTH);

    logic                  mode_reg;
    logic [31:0]           length_reg;

    lzss_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]            flag_reg, flag_next;
    logic [3:0]            items_reg, items_next;
    logic [2:0]            key_reg, key_next;
    logic [7:0]            low_reg, low_next;

    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic                  wrapped_reg, wrapped_next;
    logic [31:0]           count_reg, count_next;

    logic                  copy_reg, copy_next;
    logic [4:0]            left_reg, left_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_ram_reg, s1_ram_next;
    logic [7:0]            s1_byte_reg, s1_byte_next;
    logic                  s1_last_reg, s1_last_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    logic                  adv;
    logic                  in_take;
    logic                  consume;
    logic                  emit;
    logic                  issue;
    logic                  fwd;
    logic [7:0]            ram_rdata;
    logic [7:0]            cur_byte;
    logic [PTR_W-1:0]      wp_eff;
    logic [15:0]           word;
    logic [PTR_W:0]        diff;
    logic [PTR_W-1:0]      src;
    logic [7:0]            flag_shift;
    logic [3:0]            items_dec;
    logic                  cfg_wr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            length_reg <= lzss_pkg::LENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                lzss_pkg::REG_MODE:   mode_reg   <= pwdata[0];
                lzss_pkg::REG_LENGTH: length_reg <= pwdata;
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lzss_pkg::REG_MODE:   prdata = {31'd0, mode_reg};
            lzss_pkg::REG_LENGTH: prdata = length_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // Pipeline control
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && !copy_reg && !(s_axis_tuser && s1_valid_reg);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign consume       = adv && s1_valid_reg;
    assign emit          = consume && (count_reg < length_reg);
    assign issue         = adv && copy_reg;

    assign cur_byte = s1_ram_reg ? ram_rdata : s1_byte_reg;
    assign fwd      = s1_valid_reg && (rd_ptr_reg == wr_ptr_reg);

    assign wp_eff = s1_valid_reg
                  ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1)
                  : wr_ptr_reg;

    assign word = mode_reg ? ({s_axis_tdata, low_reg} ^ lzss_pkg::match_key(key_reg))
                           : {s_axis_tdata, low_reg};
    assign diff = {1'b0, wp_eff} - (PTR_W + 1)'(word[11:0]);
    assign src  = diff[PTR_W] ? PTR_W'(diff + DEPTH_X) : diff[PTR_W-1:0];

    assign flag_shift = {1'b0, flag_reg[7:1]};
    assign items_dec  = (items_reg != 4'd0) ? items_reg - 4'd1 : 4'd0;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (consume),
        .waddr (wr_ptr_reg),
        .wdata (cur_byte),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Item decode
    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        items_next = items_reg;
        key_next   = key_reg;
        low_next   = low_reg;
        copy_next  = copy_reg;
        left_next  = left_reg;
        rd_ptr_next = rd_ptr_reg;

        s1_valid_next = adv ? 1'b0 : s1_valid_reg;
        s1_ram_next   = s1_ram_reg;
        s1_byte_next  = s1_byte_reg;
        s1_last_next  = s1_last_reg;

        if (issue)
        begin
            s1_valid_next = 1'b1;
            s1_ram_next   = !fwd && (wrapped_reg || (rd_ptr_reg < wr_ptr_reg));
            s1_byte_next  = fwd ? cur_byte : 8'd0;
            s1_last_next  = (left_reg == 5'd0);
            rd_ptr_next   = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            left_next     = left_reg - 5'd1;
            copy_next     = (left_reg != 5'd0);
        end

        if (in_take)
        begin
            if (s_axis_tuser)
            begin
                key_next   = s_axis_tdata[5:3];
                flag_next  = mode_reg ? (s_axis_tdata ^ lzss_pkg::FLAG_XOR) : s_axis_tdata;
                items_next = lzss_pkg::GROUP_ITEMS;
                phase_next = lzss_pkg::PH_ITEM;
                low_next   = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    lzss_pkg::PH_ITEM:
                    begin
                        if (flag_reg[0])
                        begin
                            low_next   = s_axis_tdata;
                            phase_next = lzss_pkg::PH_HIGH;
                        end
                        else
                        begin
                            s1_valid_next = 1'b1;
                            s1_ram_next   = 1'b0;
                            s1_byte_next  = s_axis_tdata;
                            s1_last_next  = 1'b1;
                            flag_next     = flag_shift;
                            items_next    = items_dec;
                            phase_next    = (items_dec == 4'd0) ? lzss_pkg::PH_FLAG
                                                                : lzss_pkg::PH_ITEM;
                        end
                    end
                    lzss_pkg::PH_HIGH:
                    begin
                        copy_next   = 1'b1;
                        left_next   = {1'b0, word[15:12]} + 5'd1;
                        rd_ptr_next = src;
                        flag_next   = flag_shift;
                        items_next  = items_dec;
                        phase_next  = (items_dec == 4'd0) ? lzss_pkg::PH_FLAG
                                                          : lzss_pkg::PH_ITEM;
                    end
                    default:
                    begin
                        key_next   = s_axis_tdata[5:3];
                        flag_next  = mode_reg ? (s_axis_tdata ^ lzss_pkg::FLAG_XOR)
                                              : s_axis_tdata;
                        items_next = lzss_pkg::GROUP_ITEMS;
                        phase_next = lzss_pkg::PH_ITEM;
                    end
                endcase
            end
        end
    end

    // History write side and output
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        wrapped_next = wrapped_reg;
        count_next   = count_reg;

        if (consume)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (wr_ptr_reg == PTR_LAST)
            begin
                wrapped_next = 1'b1;
            end
        end
        if (emit)
        begin
            count_next = count_reg + 32'd1;
        end
        if (in_take && s_axis_tuser)
        begin
            wr_ptr_next  = '0;
            wrapped_next = 1'b0;
            count_next   = 32'd0;
        end

        out_valid_next = adv ? emit : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (emit)
        begin
            out_byte_next = cur_byte;
            out_done_next = ((count_reg + 32'd1) == length_reg);
            out_last_next = s1_last_reg || ((count_reg + 32'd1) == length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lzss_pkg::PH_FLAG;
            flag_reg      <= 8'd0;
            items_reg     <= 4'd0;
            key_reg       <= 3'd0;
            low_reg       <= 8'd0;
            wr_ptr_reg    <= '0;
            wrapped_reg   <= 1'b0;
            count_reg     <= 32'd0;
            copy_reg      <= 1'b0;
            left_reg      <= 5'd0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            items_reg     <= items_next;
            key_reg       <= key_next;
            low_reg       <= low_next;
            wr_ptr_reg    <= wr_ptr_next;
            wrapped_reg   <= wrapped_next;
            count_reg     <= count_next;
            copy_reg      <= copy_next;
            left_reg      <= left_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ram_reg   <= s1_ram_next;
        s1_byte_reg  <= s1_byte_next;
        s1_last_reg  <= s1_last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

    a_copy_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        copy_reg |-> !s_axis_tready
    ) else $error("input taken during match copy");

    a_copy_end_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(copy_reg) |-> (s1_valid_reg && s1_last_reg)
    ) else $error("match copy ended without a final byte in flight");

    a_write_advances: assert property (
        @(posedge clk) disable iff (!rst_n)
        (consume && !(in_take && s_axis_tuser) && (wr_ptr_reg != PTR_LAST))
            |=> (wr_ptr_reg == $past(wr_ptr_reg) + 1'b1)
    ) else $error("history write pointer did not advance");

    a_restart_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_take && s_axis_tuser) |=> (wr_ptr_reg == '0 && !wrapped_reg && count_reg == 32'd0)
    ) else $error("stream restart did not clear history fill");

endmodule

`default_nettype wire

>>> tb/sv/lzss_decode_checker.sv
`default_nettype none

module lzss_decode_checker
    import lzss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [7:0]            s_data,
    input  wire logic                  s_start,

    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [7:0]            m_data,
    input  wire logic                  m_last,
    input  wire logic                  m_done,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic                  pready,

    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);

    // index 0 in the lowest slice
    localparam logic [7:0][15:0] WORD_KEYS = {
        16'h0233, 16'h4765, 16'h815f, 16'hf237,
        16'h0034, 16'h675f, 16'h834f, 16'hff21
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_beat_t;

    out_beat_t        expected_bytes[$];
    int               err_count;

    logic             xor_mode;
    logic [31:0]      size_limit;

    phase_t           cur_phase;
    logic [7:0]       flag_sr;
    logic [3:0]       group_left;
    logic [2:0]       key_idx;
    logic [7:0]       low_byte;
    logic [7:0]       ring[HISTORY_DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [31:0]      emitted;

    task automatic restart_stream();
        cur_phase  = PH_FLAG;
        flag_sr    = '0;
        group_left = '0;
        key_idx    = '0;
        low_byte   = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            ring[i] = '0;
        wr_ptr     = '0;
        emitted    = '0;
    endtask

    task automatic emit(input logic [7:0] v);
        out_beat_t beat;
        ring[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (emitted < size_limit)
        begin
            emitted   = emitted + 1;
            beat.data = v;
            beat.last = 1'b0;
            beat.done = (emitted == size_limit);
            expected_bytes.push_back(beat);
        end
    endtask

    task automatic finish_item();
        flag_sr = flag_sr >> 1;
        if (group_left != 0)
            group_left = group_left - 1'b1;
        cur_phase = (group_left == 0) ? PH_FLAG : PH_ITEM;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [15:0]      word;
        logic [PTR_W-1:0] src;
        int               len;
        int               before_cnt;
        out_beat_t        tail;
        if (start)
            restart_stream();
        before_cnt = expected_bytes.size();
        case (cur_phase)
            PH_ITEM:
            begin
                if (flag_sr[0])
                begin
                    low_byte  = b;
                    cur_phase = PH_HIGH;
                end
                else
                begin
                    emit(b);
                    finish_item();
                end
            end
            PH_HIGH:
            begin
                word = {b, low_byte};
                if (xor_mode)
                    word = word ^ WORD_KEYS[key_idx];
                len = int'(word[15:12]) + 2;
                src = wr_ptr - PTR_W'(word[11:0]);
                for (int i = 0; i < len; i++)
                begin
                    emit(ring[src]);
                    src = src + 1'b1;
                end
                finish_item();
            end
            default:
            begin
                key_idx    = b[5:3];
                flag_sr    = xor_mode ? (b ^ FLAG_XOR) : b;
                group_left = GROUP_ITEMS;
                cur_phase  = PH_ITEM;
            end
        endcase
        if (expected_bytes.size() > before_cnt)
        begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t beat;
        if (!rst_n)
        begin
            xor_mode   = 1'b0;
            size_limit = LENGTH_RESET;
            restart_stream();
            expected_bytes.delete();
            err_count  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[CFG_ADDR_W-1:2] == REG_MODE)
                    xor_mode = pwdata[0];
                else if (paddr[CFG_ADDR_W-1:2] == REG_LENGTH)
                    size_limit = pwdata;
            end

            if (s_valid && s_ready)
                decode_byte(s_data, s_start);

            if (m_valid && m_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: expected none, got %02h", m_data);
                    err_count++;
                end
                else
                begin
                    beat = expected_bytes.pop_front();
                    if (m_data !== beat.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", beat.data, m_data);
                        err_count++;
                    end
                    if (m_last !== beat.last)
                    begin
                        $error("run_last: expected %0b, got %0b", beat.last, m_last);
                        err_count++;
                    end
                    if (m_done !== beat.done)
                    begin
                        $error("stream_done: expected %0b, got %0b", beat.done, m_done);
                        err_count++;
                    end
                end
            end
        end
        errors  <= err_count;
        pending <= expected_bytes.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_lzss_stream_decoder.sv
`default_nettype none

module tb_lzss_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import lzss_pkg::*;

    localparam int                    SETTLE      = 40;
    localparam int                    HOLD_CYCLES = 300;
    localparam int                    DRAIN_LIMIT = 20000;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MODE   = {REG_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_LENGTH = {REG_LENGTH, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    errors;
    int                    pending;

    int                    src_idle_pct;
    int                    dst_stall_pct;
    bit                    hold_req;
    logic                  mode_now;
    int                    bytes_sent;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lzss_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lzss_decode_checker decode_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_start (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast),
        .m_done  (m_axis_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_lzss_stream_decoder: errors");
        $finish;
    end

    task automatic offer_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // hold input until every expected byte is out, then let the copy engine settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic mode, input logic [31:0] length);
        apb_write(ADDR_MODE, {31'b0, mode});
        apb_write(ADDR_LENGTH, length);
        mode_now = mode;
    endtask

    // flag byte plus eight items, match words mostly pointing at recent history
    task automatic send_group(input logic start);
        logic [7:0]  raw;
        logic [7:0]  eff;
        logic [15:0] word;
        logic [15:0] enc;
        raw = 8'($urandom);
        offer_byte(raw, start);
        eff = mode_now ? (raw ^ FLAG_XOR) : raw;
        for (int i = 0; i < 8; i++)
        begin
            if (eff[i])
            begin
                word[15:12] = 4'($urandom);
                word[11:0]  = ($urandom_range(3) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(1, 24));
                enc = mode_now ? (word ^ match_key(raw[5:3])) : word;
                offer_byte(enc[7:0], 1'b0);
                offer_byte(enc[15:8], 1'b0);
            end
            else
                offer_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic run_phase(input int src_pct, input int dst_pct, input logic mode,
                             input logic [31:0] length, input int count, input bit with_hold);
        int target;
        bit fresh;
        bit hold_pending;
        drain();
        set_regs(mode, length);
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        target        = bytes_sent + count;
        fresh         = 1'b1;
        hold_pending  = with_hold;
        while (bytes_sent < target)
        begin
            if (hold_pending && bytes_sent >= target - count / 2)
            begin
                hold_req     = 1'b1;
                hold_pending = 1'b0;
            end
            if ($urandom_range(7) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    offer_byte(8'($urandom), $urandom_range(3) == 0);
                fresh = 1'b1;
            end
            send_group(fresh || $urandom_range(5) == 0);
            fresh = 1'b0;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_req      = 1'b0;
        mode_now      = 1'b0;
        bytes_sent    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(1'b0, LENGTH_RESET);
        // literal, overlapping long match, distance zero, farthest distance
        offer_byte(8'hfe, 1'b1);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'h01, 1'b0);
        offer_byte(8'hf0, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(8'hff, 1'b0);
        // switch to obfuscated mode between the two halves of a match word
        offer_byte(8'h34, 1'b0);
        drain();
        apb_write(ADDR_MODE, 32'd1);
        mode_now = 1'b1;
        offer_byte(8'h02, 1'b0);
        // restart in the middle of a group
        offer_byte(8'hc8, 1'b1);
        offer_byte(8'h01, 1'b0);
        offer_byte(8'h80, 1'b0);
        // output limit reached mid-stream
        drain();
        apb_write(ADDR_LENGTH, 32'd4);
        offer_byte(8'h10, 1'b0);
        offer_byte(8'h20, 1'b0);
        offer_byte(8'h30, 1'b0);
        // zero length suppresses everything
        drain();
        set_regs(1'b0, 32'd0);
        offer_byte(8'h03, 1'b1);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h10, 1'b0);
        offer_byte(8'h7f, 1'b0);
        offer_byte(8'ha5, 1'b0);

        run_phase(0,  0,  1'b0, LENGTH_RESET,                40, 1'b0);
        run_phase(59, 0,  1'b1, 32'($urandom_range(60, 250)), 40, 1'b0);
        run_phase(0,  59, 1'b0, 32'hffff_fffe,               40, 1'b1);
        run_phase(16, 16, 1'b1, 32'($urandom_range(100, 400)), 40, 1'b0);

        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb_lzss_stream_decoder: clean");
        else
            $display("tb_lzss_stream_decoder: errors");
        $finish;
    end

endmodule

`default_nettype wire
